// ----- rtl/fpsc_pkg.sv -----
`timescale 1ns / 1ps

package fpsc_pkg;

    // Angle constants in 16.16 fixed point.
    localparam logic [17:0] PI_Q16      = 18'h3243F;
    localparam logic [31:0] HALF_PI_Q16 = 32'h0001921F;

    // Polynomial coefficients in 16.16 fixed point.
    localparam logic [15:0] COEF_A = 16'h099F;
    localparam logic [15:0] COEF_B = 16'h3C71;
    localparam logic [15:0] COEF_C = 16'h0EEC;
    localparam logic [15:0] COEF_D = 16'hFB62;

    // Reciprocal of pi scaled by 2^32, rounded down. The quotient estimate
    // floor(x * RECIP_PI / 2^32) is low by at most one for any x up to 2^31.
    localparam int          RECIP_SHIFT = 32;
    localparam logic [14:0] RECIP_PI    = 15'((64'd1 << RECIP_SHIFT) / 64'(PI_Q16));

    // Control that travels alongside the data in pipeline stages 2 to 10.
    typedef struct packed {
        logic vld;
        logic neg;
    } t_tag;

endpackage

// ----- rtl/fpsc_mod_pi.sv -----
`timescale 1ns / 1ps

module fpsc_mod_pi (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [31:0]       i_x,
    input  fpsc_pkg::t_tag    i_tag,
    output logic [17:0]       o_x,
    output fpsc_pkg::t_tag    o_tag
);
    import fpsc_pkg::*;

    logic [46:0] w_qprod;
    logic [18:0] w_rem;
    logic        w_ge;

    t_tag        r3_tag, r4_tag, r5_tag, r6_tag;
    logic [31:0] r3_x, r4_x;
    logic [14:0] r3_q;
    logic [32:0] r4_m;
    logic        r4_q0, r5_q0, r5_gt;
    logic [18:0] r5_rem;
    logic [17:0] r5_xlo, r6_x;
    logic [17:0] n6_x;
    logic        n6_neg;

    // Quotient estimate through the reciprocal; it is exact or one short.
    assign w_qprod = 47'(i_x) * 47'(RECIP_PI);

    // Final correction: at most one subtraction of pi remains.
    assign w_ge  = (r5_rem >= 19'(PI_Q16));
    assign w_rem = w_ge ? (r5_rem - 19'(PI_Q16)) : r5_rem;

    always_comb begin
        n6_x   = r5_gt ? w_rem[17:0] : r5_xlo;
        n6_neg = r5_tag.neg ^ (r5_gt & (r5_q0 ^ w_ge));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_tag.vld <= 1'b0;
            r4_tag.vld <= 1'b0;
            r5_tag.vld <= 1'b0;
            r6_tag.vld <= 1'b0;
        end else if (i_en) begin
            r3_tag <= i_tag;
            r4_tag <= r3_tag;
            r5_tag <= r4_tag;
            r6_tag <= '{vld: r5_tag.vld, neg: n6_neg};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_x   <= i_x;
            r3_q   <= w_qprod[46:RECIP_SHIFT];
            r4_x   <= r3_x;
            r4_m   <= 33'(r3_q) * 33'(PI_Q16);
            r4_q0  <= r3_q[0];
            r5_rem <= 19'(r4_x - r4_m[31:0]);
            r5_gt  <= (r4_x > 32'(PI_Q16));
            r5_xlo <= r4_x[17:0];
            r5_q0  <= r4_q0;
            r6_x   <= n6_x;
        end
    end

    assign o_x   = r6_x;
    assign o_tag = r6_tag;

endmodule

// ----- rtl/fpsc_poly.sv -----
`timescale 1ns / 1ps

module fpsc_poly (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic [17:0]         i_x,
    input  fpsc_pkg::t_tag      i_tag,
    output logic signed [18:0]  o_value,
    output logic                o_valid
);
    import fpsc_pkg::*;

    logic [33:0] w_td;
    logic [35:0] w_p2, w_tc;
    logic [37:0] w_p3, w_tb;
    logic [39:0] w_p4, w_ta;
    logic signed [24:0] w_sum, w_res;

    t_tag        r7_tag, r8_tag, r9_tag, r10_tag;
    logic        r11_vld;
    logic [17:0] r7_x, r8_x, r7_td;
    logic [19:0] r7_p2;
    logic [20:0] r8_spos, r9_spos, r10_spos;
    logic [21:0] r8_p3, r9_tb, r10_tb;
    logic [23:0] r9_p4, r10_ta;
    logic signed [18:0] r11_value;

    // Every product is floored to 16.16 before the next stage uses it.
    assign w_td = 34'(COEF_D) * 34'(i_x);
    assign w_p2 = 36'(i_x) * 36'(i_x);
    assign w_tc = 36'(COEF_C) * 36'(r7_p2);
    assign w_p3 = 38'(r7_p2) * 38'(r7_x);
    assign w_tb = 38'(COEF_B) * 38'(r8_p3);
    assign w_p4 = 40'(r8_p3) * 40'(r8_x);
    assign w_ta = 40'(COEF_A) * 40'(r9_p4);

    assign w_sum = $signed(25'(r10_spos)) + $signed(25'(r10_ta)) - $signed(25'(r10_tb));
    assign w_res = r10_tag.neg ? -w_sum : w_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_tag.vld  <= 1'b0;
            r8_tag.vld  <= 1'b0;
            r9_tag.vld  <= 1'b0;
            r10_tag.vld <= 1'b0;
            r11_vld     <= 1'b0;
        end else if (i_en) begin
            r7_tag  <= i_tag;
            r8_tag  <= r7_tag;
            r9_tag  <= r8_tag;
            r10_tag <= r9_tag;
            r11_vld <= r10_tag.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r7_x      <= i_x;
            r7_td     <= w_td[33:16];
            r7_p2     <= w_p2[35:16];
            r8_x      <= r7_x;
            r8_spos   <= 21'(r7_td) + 21'(w_tc[35:16]);
            r8_p3     <= w_p3[37:16];
            r9_spos   <= r8_spos;
            r9_tb     <= w_tb[37:16];
            r9_p4     <= w_p4[39:16];
            r10_spos  <= r9_spos;
            r10_tb    <= r9_tb;
            r10_ta    <= w_ta[39:16];
            r11_value <= w_res[18:0];
        end
    end

    assign o_value = r11_value;
    assign o_valid = r11_vld;

endmodule

// ----- rtl/fixed_point_sine_cosine.sv -----
`timescale 1ns / 1ps
// Fixed-point sine/cosine unit, signed 16.16 angle in, signed 3.16 value out.
// Throughput: one transaction per cycle while the output is not stalled; the depth
// is set by the chain of dependent multipliers (quotient estimate, pi product,
// x^2, x^3, x^4 terms).
// Reset (synchronous, active low) clears every stage valid bit at once.

module fixed_point_sine_cosine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_action,
    input  logic signed [31:0] i_angle,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [18:0] o_value
);
    import fpsc_pkg::*;

    // The whole pipeline moves as one. It only holds when a finished result
    // sits in the output register and the downstream side stalls it, so a
    // new transaction is accepted in every cycle that the output drains.
    logic w_adv;

    // Stage 1: cosine is computed as sine of the angle plus pi/2, with the
    // sum wrapping modulo 2^32 just like the 32-bit angle itself.
    logic        r1_vld;
    logic [31:0] r1_ang;
    logic [31:0] n1_ang;

    // Stage 2: magnitude of the angle and the sign flip that goes with it.
    // The most negative angle yields magnitude 2^31, which is still reduced
    // correctly below.
    t_tag        r2_tag;
    logic [31:0] r2_x;
    logic [31:0] n2_x;
    logic        n2_neg;

    // Stages 3 to 6 reduce the magnitude modulo pi, toggling the sign on an
    // odd quotient. A magnitude of exactly pi is left as pi.
    logic [17:0] w_xr;
    t_tag        w_xr_tag;

    assign o_stall = o_valid & i_stall;
    assign w_adv   = ~o_stall;

    always_comb begin
        n1_ang = $unsigned(i_angle) + (i_action ? HALF_PI_Q16 : 32'd0);
        n2_neg = r1_ang[31];
        n2_x   = n2_neg ? (32'd0 - r1_ang) : r1_ang;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld     <= 1'b0;
            r2_tag.vld <= 1'b0;
        end else if (w_adv) begin
            r1_vld <= i_valid;
            r2_tag <= '{vld: r1_vld, neg: n2_neg};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_ang <= n1_ang;
            r2_x   <= n2_x;
        end
    end

    fpsc_mod_pi u_mod_pi (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_x     (r2_x),
        .i_tag   (r2_tag),
        .o_x     (w_xr),
        .o_tag   (w_xr_tag)
    );

    // Stages 7 to 11 evaluate d*x + c*x^2 - b*x^3 + a*x^4 on the reduced
    // angle, apply the sign flip to the final sum and keep the low 19 bits.
    // The last stage is the output register.
    fpsc_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_x     (w_xr),
        .i_tag   (w_xr_tag),
        .o_value (o_value),
        .o_valid (o_valid)
    );

endmodule

// ----- rtl/fpsc_chk.sv -----
`timescale 1ns / 1ps

module fpsc_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [18:0] o_value
);

    // Reset empties the pipeline, so no result is offered afterwards.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result offered right after reset");

    // Reset also releases back-pressure toward the sender.
    a_reset_no_stall: assert property (@(posedge i_clk) !i_rst_n |=> !o_stall)
        else $error("input stalled right after reset");

    // Back-pressure only arises from a waiting result that is being stalled.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a stalled result");

    // A stalled result stays offered and unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_value)))
        else $error("stalled result changed or vanished");

endmodule

bind fixed_point_sine_cosine fpsc_chk u_fpsc_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_value (o_value)
);

// ----- tb/fixed_point_sine_cosine_tb.sv -----
`timescale 1ns / 1ps

module fixed_point_sine_cosine_tb;

    // Selector encoding on i_action.
    typedef enum logic {
        TRIG_SINE   = 1'b0,
        TRIG_COSINE = 1'b1
    } t_trig_op;

    // 16.16 constants of the approximation, kept local so that the expected
    // values do not lean on anything inside the design.
    localparam logic [63:0] PI_FIX      = 64'h3243F;
    localparam logic [31:0] HALF_PI_FIX = 32'h1921F;
    localparam logic [63:0] POLY_A      = 64'h099F;
    localparam logic [63:0] POLY_B      = 64'h3C71;
    localparam logic [63:0] POLY_C      = 64'h0EEC;
    localparam logic [63:0] POLY_D      = 64'hFB62;

    localparam int RANDOM_ITEMS   = 750;
    localparam int HOLD_OFF_SPAN  = 64;   // Receiver hold-off length in cycles.
    localparam int DRAIN_CYCLES   = 30;   // Comfortably above the pipeline latency.
    localparam int WATCHDOG_LIMIT = 2000; // Cycles with no transaction on either side.
    localparam int MAX_REPORTS    = 20;

    // Keeps the expected values of accepted angles in arrival order and
    // compares every delivered value against the oldest one.
    class t_trig_scoreboard;
        logic [18:0] expected_values[$];
        int errors;
        int compared;
        int sine_count;
        int cosine_count;

        function new();
            errors       = 0;
            compared     = 0;
            sine_count   = 0;
            cosine_count = 0;
        endfunction

        // Floored 16.16 product of two non-negative operands.
        function logic [63:0] floor_mul(logic [63:0] p, logic [63:0] q);
            return (p * q) >> 16;
        endfunction

        function logic [18:0] predict_trig_value(t_trig_op op, logic [31:0] angle);
            logic [31:0]        ang;
            logic               flip;
            logic [63:0]        x;
            logic [63:0]        pw;
            logic [63:0]        plus_terms;
            logic [63:0]        minus_term;
            logic signed [63:0] total;

            ang  = angle;
            flip = 1'b0;
            // Cosine is sine shifted by a quarter turn; the add wraps at 32 bits.
            if (op == TRIG_COSINE)
                ang = ang + HALF_PI_FIX;
            // Fold negative angles, keeping the magnitude as an unsigned value.
            if (ang[31]) begin
                ang  = 32'd0 - ang;
                flip = 1'b1;
            end
            x = {32'd0, ang};
            // Every odd half turn flips the sign of the result.
            if (x > PI_FIX) begin
                if ((x / PI_FIX) % 2 == 1)
                    flip = ~flip;
                x = x % PI_FIX;
            end
            plus_terms = floor_mul(POLY_D, x);
            pw         = floor_mul(x, x);
            plus_terms = plus_terms + floor_mul(POLY_C, pw);
            pw         = floor_mul(pw, x);
            minus_term = floor_mul(POLY_B, pw);
            pw         = floor_mul(pw, x);
            plus_terms = plus_terms + floor_mul(POLY_A, pw);
            total      = $signed(plus_terms) - $signed(minus_term);
            if (flip)
                total = -total;
            return total[18:0];
        endfunction

        function void note_angle(t_trig_op op, logic [31:0] angle);
            expected_values.push_back(predict_trig_value(op, angle));
            if (op == TRIG_COSINE)
                cosine_count++;
            else
                sine_count++;
        endfunction

        function void check_value(logic [18:0] actual);
            logic [18:0] want;

            if (expected_values.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result with nothing expected, actual %0d (0x%05h)",
                             $time, $signed(actual), actual);
                return;
            end
            want = expected_values.pop_front();
            compared++;
            if (actual !== want) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: value mismatch, expected %0d (0x%05h), actual %0d (0x%05h)",
                             $time, $signed(want), want, $signed(actual), actual);
            end
        endfunction

        function int pending();
            return expected_values.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic               i_action;
    logic signed [31:0] i_angle;
    logic               o_valid;
    logic               i_stall;
    logic signed [18:0] o_value;

    t_trig_scoreboard sb = new();

    // Requests from the stimulus for a long receiver hold-off. The receiver
    // keeps its own count of how many it has served.
    int hold_requests = 0;

    // Directed corner angles, each sent once as sine and once as cosine.
    // They cover zero, the all-ones word, a quarter turn, pi itself (which is
    // not reduced), just above pi, minus pi, an odd multiple of pi, both ends
    // of the signed range including the most negative value, and the two
    // angles whose cosine offset lands on the most negative value and on zero.
    logic [31:0] corner_angles [0:11] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h0001_921F, 32'h0003_243F,
        32'h0003_2440, 32'hFFFC_DBC1, 32'h0009_6CBD, 32'h7FFF_FFFF,
        32'h8000_0000, 32'h8000_0001, 32'h7FFE_6DE1, 32'hFFFE_6DE1
    };

    fixed_point_sine_cosine dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_action (i_action),
        .i_angle  (i_angle),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_value  (o_value)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Both sides are observed in one process at the rising edge, the input
    // transaction first, so the order within the time step never matters.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                sb.note_angle(t_trig_op'(i_action), i_angle);
            if (o_valid && !i_stall)
                sb.check_value(o_value);
        end
    end

    // The watchdog ends the run when neither side has moved a transaction
    // for too long.
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                     $time, WATCHDOG_LIMIT, sb.pending());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // The receiver switches between a few stall patterns of random length:
    // never stalling, stalling lightly or heavily at random, and a fixed
    // on/off rhythm. A hold-off request overrides all of them.
    initial begin
        int mode;
        int mode_left;
        int hold_left;
        int holds_served;
        int rhythm;

        i_stall      = 1'b0;
        mode         = 0;
        mode_left    = 0;
        hold_left    = 0;
        holds_served = 0;
        rhythm       = 0;
        forever begin
            @(negedge i_clk);
            if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                hold_left    = HOLD_OFF_SPAN;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            rhythm++;
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                case (mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 99) < 25);
                    2: i_stall <= ($urandom_range(0, 99) < 70);
                    default: i_stall <= (rhythm % 5 < 2);
                endcase
            end
        end
    end

    // Presents one angle and holds it until the block takes it.
    task automatic send_angle(input t_trig_op op, input logic [31:0] angle);
        @(negedge i_clk);
        i_valid  <= 1'b1;
        i_action <= op;
        i_angle  <= angle;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Drops valid for the given number of cycles (at least one).
    task automatic pause_input(input int cycles);
        @(negedge i_clk);
        i_valid <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    task automatic wait_for_drain();
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    // Random angles from several families: any 32-bit word, small angles of
    // either sign, values right around multiples of pi, values near both
    // ends of the signed range, and angles already inside [0, pi].
    function automatic logic [31:0] pick_angle();
        logic [31:0] k;
        logic [31:0] a;

        case ($urandom_range(0, 4))
            0: a = $urandom;
            1: a = $urandom_range(0, 8 * 32'h3243F) - 4 * 32'h3243F;
            2: begin
                k = $urandom_range(0, 10430);
                a = k * 32'h3243F + $urandom_range(0, 6) - 3;
                if ($urandom_range(0, 1) == 1)
                    a = 32'd0 - a;
            end
            3: begin
                if ($urandom_range(0, 1) == 1)
                    a = 32'h7FFF_FFFF - $urandom_range(0, 300000);
                else
                    a = 32'h8000_0000 + $urandom_range(0, 300000);
            end
            default: a = $urandom_range(0, 32'h3243F);
        endcase
        return a;
    endfunction

    initial begin
        int sent;
        int burst;
        bit hold_done;
        bit drain_done;

        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_action   = TRIG_SINE;
        i_angle    = '0;
        sent       = 0;
        hold_done  = 1'b0;
        drain_done = 1'b0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed corners back to back.
        foreach (corner_angles[n]) begin
            send_angle(TRIG_SINE, corner_angles[n]);
            send_angle(TRIG_COSINE, corner_angles[n]);
        end

        // Random traffic in bursts. Roughly one gap in four is skipped so that
        // some bursts run straight into each other.
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 30);
            repeat (burst) begin
                send_angle(t_trig_op'($urandom_range(0, 1)), pick_angle());
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                pause_input($urandom_range(1, 8));

            // Once, the receiver holds off for a long stretch while this side
            // keeps offering angles, so the pipeline fills and stalls its input.
            if (sent >= 250 && !hold_done) begin
                hold_done = 1'b1;
                hold_requests++;
            end

            // Once, this side stops until every outstanding result is back.
            if (sent >= 500 && !drain_done) begin
                drain_done = 1'b1;
                pause_input(1);
                wait_for_drain();
            end
        end

        pause_input(1);
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d sine and %0d cosine transactions, %0d values compared,",
                 sb.sine_count, sb.cosine_count, sb.compared);
        $display("including directed corners, a long receiver hold-off and a full drain.");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d errors, %0d results never delivered", sb.errors, sb.pending());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
